// ----- sv/vrrb_pkg.sv -----
`default_nettype none

package vrrb_pkg;

    // request kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_UPDATE       = 2'd0,
        OP_SET_VELOCITY = 2'd1,
        OP_RESTART      = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAX_ACCEL   = 2'd0,
        CFG_ENTRY_THR   = 2'd1,
        CFG_EXIT_THR    = 2'd2
    } cfg_index_t;

    localparam int unsigned VelW    = 32;
    localparam int unsigned AccelW  = 32;
    localparam int unsigned ThrW    = 31;
    localparam int unsigned MsW     = 16;
    localparam int unsigned ProdW   = AccelW + MsW;

    // reset values of the configuration registers
    localparam logic [AccelW-1:0] MaxAccelReset = 32'd65536;
    localparam logic [ThrW-1:0]   EntryThrReset = 31'd655;
    localparam logic [ThrW-1:0]   ExitThrReset  = 31'd65536;

    // floor(n / 1000) == (n * Recip) >> RecipShift for every n below 2**48
    localparam int unsigned RecipW     = 49;
    localparam int unsigned RecipShift = 58;
    localparam logic [RecipW-1:0] Recip = 49'd288230376151712;

    // partial product split
    localparam int unsigned HalfW  = 24;
    localparam int unsigned SumW   = ProdW + RecipW;
    localparam int unsigned QuotW  = SumW - RecipShift;

    typedef struct packed {
        op_t                   op;
        logic signed [VelW-1:0] reference;
        logic signed [VelW-1:0] new_velocity;
    } cmd_t;

    typedef struct packed {
        cmd_t            cmd;
        logic [MsW-1:0]  elapsed_ms;
    } req_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [VelW-1:0]  step;
    } step_req_t;

endpackage

`default_nettype wire

// ----- sv/velocity_ramp_with_reversal_brake.sv -----
`default_nettype none

// channel   dir  handshake          payload
// --------  ---  -----------------  ---------------------------------------------
// s_*       in   s_tvalid/s_tready  tuser op; tdata reference, elapsed_ms,
//                                   new_velocity
// m_*       out  m_tvalid/m_tready  tdata velocity, braking
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// one request per cycle is taken while m_tready is not held low; each result passes through
// the input register, accel x ms product, four partial products of the
// divide-by-1000 reciprocal, quotient sum, then the state update into m_tdata
// the state update is the last stage, so requests follow each other without gaps
// rst_n clears the pipeline, the ramp state and loads the register defaults
// a stalled m_tready only holds the stages that are full; empty ones keep filling

module velocity_ramp_with_reversal_brake
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // reference[31:0], elapsed_ms[47:32],
                                        // new_velocity[79:48]
    input  wire logic [1:0]  s_tuser,   // op[1:0]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // velocity[31:0], braking[32], zero[39:33]

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int unsigned VW = vrrb_pkg::VelW;
    localparam int unsigned TW = vrrb_pkg::ThrW;

    // configuration registers
    logic [vrrb_pkg::AccelW-1:0] max_accel_reg;
    logic [TW-1:0]               entry_thr_reg;
    logic [TW-1:0]               exit_thr_reg;

    // ramp state
    logic signed [VW-1:0] velocity_reg, velocity_next;
    logic                 brake_reg, brake_next;
    logic signed [VW-1:0] pending_reg, pending_next;

    // result register
    logic                 m_valid_reg;
    logic signed [VW-1:0] m_velocity_reg;
    logic                 m_braking_reg;

    vrrb_pkg::req_t       in_req;
    vrrb_pkg::step_req_t  st_req;
    logic                 st_valid;
    logic                 out_rdy;

    // update datapath
    logic [VW-1:0]        speed;
    logic                 vel_pos, vel_neg, ref_pos, ref_neg;
    logic                 reversal, entry_hit, brake_mid, exit_hit;
    logic signed [VW-1:0] pending_mid;
    logic signed [VW-1:0] target;
    logic [VW:0]          diff;
    logic [VW:0]          adiff;
    logic [VW:0]          step_up, step_down;
    logic signed [VW-1:0] ramped;

    assign in_req.cmd.op           = vrrb_pkg::op_t'(s_tuser);
    assign in_req.cmd.reference    = s_tdata[31:0];
    assign in_req.elapsed_ms       = s_tdata[47:32];
    assign in_req.cmd.new_velocity = s_tdata[79:48];

    assign out_rdy = !m_valid_reg || m_tready;

    vrrb_step_pipe u_step
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_accel (max_accel_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .out_valid (st_valid),
        .out_ready (out_rdy),
        .out_req   (st_req)
    );

    // config writes must only arrive while idle; the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_accel_reg <= vrrb_pkg::MaxAccelReset;
            entry_thr_reg <= vrrb_pkg::EntryThrReset;
            exit_thr_reg  <= vrrb_pkg::ExitThrReset;
        end
        else if (cfg_we)
        begin
            unique case (vrrb_pkg::cfg_index_t'(cfg_index))
                vrrb_pkg::CFG_MAX_ACCEL: max_accel_reg <= cfg_data;
                vrrb_pkg::CFG_ENTRY_THR: entry_thr_reg <= cfg_data[TW-1:0];
                vrrb_pkg::CFG_EXIT_THR:  exit_thr_reg  <= cfg_data[TW-1:0];
                default:                 ;
            endcase
        end
    end

    // speed with the most negative value read as 2**31
    assign speed   = velocity_reg[VW-1] ? (~velocity_reg + VW'(1)) : velocity_reg;
    assign vel_neg = velocity_reg[VW-1];
    assign vel_pos = !velocity_reg[VW-1] && (velocity_reg != '0);
    assign ref_neg = st_req.cmd.reference[VW-1];
    assign ref_pos = !st_req.cmd.reference[VW-1] && (st_req.cmd.reference != '0);
    assign reversal = (vel_pos && ref_neg) || (vel_neg && ref_pos);

    // entry check, then exit check; both may fire in one request
    assign entry_hit   = !brake_reg && reversal && (speed > {1'b0, entry_thr_reg});
    assign brake_mid   = brake_reg || entry_hit;
    assign pending_mid = entry_hit ? st_req.cmd.reference : pending_reg;
    assign exit_hit    = brake_mid && (speed < {1'b0, exit_thr_reg});

    always_comb
    begin
        if (!brake_mid)
        begin
            target = st_req.cmd.reference;
        end
        else if (exit_hit)
        begin
            target = pending_mid;
        end
        else
        begin
            target = '0;
        end
    end

    // move by at most one step, land on target otherwise
    assign diff      = {target[VW-1], target} - {velocity_reg[VW-1], velocity_reg};
    assign adiff     = diff[VW] ? (~diff + (VW+1)'(1)) : diff;
    assign step_up   = {velocity_reg[VW-1], velocity_reg} + {1'b0, st_req.step};
    assign step_down = {velocity_reg[VW-1], velocity_reg} - {1'b0, st_req.step};

    always_comb
    begin
        if (adiff > {1'b0, st_req.step})
        begin
            ramped = diff[VW] ? step_down[VW-1:0] : step_up[VW-1:0];
        end
        else
        begin
            ramped = target;
        end
    end

    always_comb
    begin
        velocity_next = velocity_reg;
        brake_next    = brake_reg;
        pending_next  = pending_reg;
        unique case (st_req.cmd.op)
            vrrb_pkg::OP_UPDATE:
            begin
                velocity_next = ramped;
                brake_next    = brake_mid && !exit_hit;
                pending_next  = pending_mid;
            end
            vrrb_pkg::OP_SET_VELOCITY:
            begin
                velocity_next = st_req.cmd.new_velocity;
            end
            vrrb_pkg::OP_RESTART:
            begin
                velocity_next = '0;
                brake_next    = 1'b0;
                pending_next  = '0;
            end
            default:
            begin
                // unused op: report state unchanged
                velocity_next = velocity_reg;
            end
        endcase
    end

    // state moves only when a request leaves the step pipe into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            velocity_reg <= '0;
            brake_reg    <= 1'b0;
            pending_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end
        else if (out_rdy)
        begin
            m_valid_reg <= st_valid;
            if (st_valid)
            begin
                velocity_reg <= velocity_next;
                brake_reg    <= brake_next;
                pending_reg  <= pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && st_valid)
        begin
            m_velocity_reg <= velocity_next;
            m_braking_reg  <= brake_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_braking_reg, m_velocity_reg};

endmodule

`default_nettype wire

// ----- sv/vrrb_step_pipe.sv -----
`default_nettype none

module vrrb_step_pipe
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [vrrb_pkg::AccelW-1:0]        max_accel,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire vrrb_pkg::req_t                     in_req,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output vrrb_pkg::step_req_t                     out_req
);

    localparam int unsigned HW = vrrb_pkg::HalfW;
    localparam int unsigned PW = vrrb_pkg::ProdW;
    localparam int unsigned RW = vrrb_pkg::RecipW;
    localparam int unsigned SW = vrrb_pkg::SumW;
    localparam int unsigned QW = vrrb_pkg::QuotW;
    localparam int unsigned VW = vrrb_pkg::VelW;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    vrrb_pkg::req_t  req1_reg;
    vrrb_pkg::cmd_t  cmd2_reg, cmd3_reg, cmd4_reg;

    logic [PW-1:0]        prod_reg;
    logic [RW-HW+HW-1:0]  pp_hh_reg;
    logic [2*HW-1:0]      pp_hl_reg;
    logic [RW-HW+HW-1:0]  pp_lh_reg;
    logic [2*HW-1:0]      pp_ll_reg;
    logic [QW-1:0]        quot_reg;

    logic [PW-1:0]        prod_next;
    logic [RW-1:0]        pp_hh_next;
    logic [2*HW-1:0]      pp_hl_next;
    logic [RW-1:0]        pp_lh_next;
    logic [2*HW-1:0]      pp_ll_next;
    logic [SW-1:0]        sum;
    logic [QW-1:0]        quot_next;

    // stage k may load when empty or when its content moves on
    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign prod_next = PW'(max_accel) * PW'(req1_reg.elapsed_ms);

    // reciprocal multiply cut into four partial products
    assign pp_hh_next = RW'(prod_reg[PW-1:HW]) * RW'(vrrb_pkg::Recip[RW-1:HW]);
    assign pp_hl_next = (2*HW)'(prod_reg[PW-1:HW]) * (2*HW)'(vrrb_pkg::Recip[HW-1:0]);
    assign pp_lh_next = RW'(prod_reg[HW-1:0]) * RW'(vrrb_pkg::Recip[RW-1:HW]);
    assign pp_ll_next = (2*HW)'(prod_reg[HW-1:0]) * (2*HW)'(vrrb_pkg::Recip[HW-1:0]);

    assign sum = (SW'(pp_hh_reg) << (2 * HW))
               + ((SW'(pp_hl_reg) + SW'(pp_lh_reg)) << HW)
               + SW'(pp_ll_reg);
    assign quot_next = sum[SW-1:vrrb_pkg::RecipShift];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            req1_reg <= in_req;
        end
        if (rdy2 && v1_reg)
        begin
            cmd2_reg <= req1_reg.cmd;
            prod_reg <= prod_next;
        end
        if (rdy3 && v2_reg)
        begin
            cmd3_reg  <= cmd2_reg;
            pp_hh_reg <= pp_hh_next;
            pp_hl_reg <= pp_hl_next;
            pp_lh_reg <= pp_lh_next;
            pp_ll_reg <= pp_ll_next;
        end
        if (rdy4 && v3_reg)
        begin
            cmd4_reg <= cmd3_reg;
            quot_reg <= quot_next;
        end
    end

    // saturate the step to 32 bits
    assign out_valid    = v4_reg;
    assign out_req.cmd  = cmd4_reg;
    assign out_req.step = (|quot_reg[QW-1:VW]) ? '1 : quot_reg[VW-1:0];

endmodule

`default_nettype wire
